// ----- src/md5sh_pkg.sv -----
`default_nettype none

package md5sh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] chain_t;

  // Buffer is kept as sixteen little-endian 32-bit words.
  localparam int BUF_WORDS = 16;
  localparam int BUF_AW    = 4;

  localparam chain_t MD5_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [7:0]        PAD_BYTE      = 8'h80;
  localparam logic [5:0]        BLOCK_LAST    = 6'h3F;
  localparam logic [BUF_AW-1:0] ZERO_LAST_IDX = 4'd13;
  localparam logic [BUF_AW-1:0] LEN_LO_IDX    = 4'd14;
  localparam logic [BUF_AW-1:0] LEN_HI_IDX    = 4'd15;

  typedef struct packed {
    logic start;
    logic reinit;
  } comp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } comp_stat_t;

  // Message word index used by step rnd.
  function automatic logic [BUF_AW-1:0] md5_g(input logic [5:0] rnd);
    logic [BUF_AW-1:0] n;
    logic [BUF_AW-1:0] g;
    n = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = n;
      2'd1:    g = (n << 2) + n + 4'd1;
      2'd2:    g = (n << 1) + n + 4'd5;
      2'd3:    g = (n << 3) - n;
      default: g = n;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      4'd15:   s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic word_t md5_k(input logic [5:0] rnd);
    word_t k;
    case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'hd76aa478;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- src/md5sh_if.sv -----
`default_nettype none

interface md5sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, output message_byte, output byte_present,
                  output last_byte, input ready);
  modport sink   (input valid, input message_byte, input byte_present,
                  input last_byte, output ready);
endinterface

interface md5sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

// ----- src/md5sh_ram.sv -----
`default_nettype none

module md5sh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/md5sh_compress.sv -----
`default_nettype none

module md5sh_compress
  import md5sh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire comp_ctrl_t        ctrl,
  output comp_stat_t             stat,
  output logic      [BUF_AW-1:0] ram_raddr,
  input  wire word_t             ram_rdata,
  output chain_t                 chain
);

  typedef enum logic [1:0] {C_IDLE, C_PRIME, C_RUN, C_FIN} cstate_t;

  cstate_t    state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  word_t      a_r, b_r, c_r, d_r;
  word_t      a_nxt, b_nxt, c_nxt, d_nxt;
  chain_t     chain_r, chain_nxt;
  logic       done_r, done_nxt;

  word_t       f;
  word_t       t;
  logic [63:0] tt;

  // one MD5 step: F, add a, message word and K, rotate, add b
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      2'd3:    f = c_r ^ (b_r | ~d_r);
      default: f = b_r ^ c_r ^ d_r;
    endcase
    t  = a_r + f + ram_rdata + md5_k(rnd_r);
    tt = {t, t} << md5_rot(rnd_r);
  end

  // word for the next step is addressed now, as the buffer read is registered
  assign ram_raddr = md5_g((state_r == C_RUN) ? (rnd_r + 6'd1) : 6'd0);

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    chain_nxt = chain_r;
    done_nxt  = 1'b0;
    case (state_r)
      C_IDLE: begin
        if (ctrl.start) begin
          state_nxt = C_PRIME;
        end
      end
      C_PRIME: begin
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        rnd_nxt   = 6'd0;
        state_nxt = C_RUN;
      end
      C_RUN: begin
        a_nxt   = d_r;
        d_nxt   = c_r;
        c_nxt   = b_r;
        b_nxt   = b_r + tt[63:32];
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = C_FIN;
        end
      end
      C_FIN: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        done_nxt     = 1'b1;
        state_nxt    = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
    if (ctrl.reinit) begin
      chain_nxt = MD5_IV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= 6'd0;
      chain_r <= MD5_IV;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      chain_r <= chain_nxt;
      done_r  <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
  end

  assign stat  = comp_stat_t'{busy: (state_r != C_IDLE), done: done_r};
  assign chain = chain_r;

endmodule

`default_nettype wire

// ----- src/md5_stream_hash.sv -----
// md5_stream_hash: streaming MD5 digest, one message byte per input transaction.
// Bytes go into the buffer one per cycle while in_ch.ready is high; then each full
// 64-byte block is compressed, one MD5 step per cycle on the shared step unit.
// After the last transaction come the padding writes, then one or two compressions;
// the four digest words then follow one per cycle while out_ch.ready is high.
// Reset (synchronous, rst_n low): chaining words to the MD5 IV, byte count to zero.
`default_nettype none

module md5_stream_hash
  import md5sh_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  md5sh_in_if.sink    in_ch,
  md5sh_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_IN,      // taking message bytes
    ST_PAD,     // write word holding the 0x80 pad byte
    ST_ZERO,    // zero fill words
    ST_LEN_LO,  // bit length, low word
    ST_LEN_HI,  // bit length, high word
    ST_COMP,    // waiting on the compressor
    ST_OUT      // digest words out
  } state_t;

  state_t            state_r, state_nxt;
  state_t            after_r, after_nxt;   // where to go once compression is done
  logic [60:0]       count_r, count_nxt;   // message byte count, wraps mod 2^61
  logic [23:0]       wbuf_r, wbuf_nxt;     // low bytes of the word being assembled
  logic [BUF_AW-1:0] zptr_r, zptr_nxt;
  logic [1:0]        oidx_r, oidx_nxt;

  logic [5:0]        pos;
  logic              ram_we;
  logic [BUF_AW-1:0] ram_waddr;
  word_t             ram_wdata;
  logic [BUF_AW-1:0] ram_raddr;
  word_t             ram_rdata;
  comp_ctrl_t        ctrl;
  comp_stat_t        stat;
  chain_t            chain;

  assign pos = count_r[5:0];

  md5sh_ram #(
    .WIDTH(32),
    .DEPTH(BUF_WORDS)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  md5sh_compress u_comp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .stat     (stat),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .chain    (chain)
  );

  always_comb begin
    state_nxt   = state_r;
    after_nxt   = after_r;
    count_nxt   = count_r;
    wbuf_nxt    = wbuf_r;
    zptr_nxt    = zptr_r;
    oidx_nxt    = oidx_r;
    ram_we      = 1'b0;
    ram_waddr   = pos[5:2];
    ram_wdata   = '0;
    ctrl.start  = 1'b0;
    ctrl.reinit = 1'b0;
    case (state_r)
      ST_IN: begin
        if (in_ch.valid) begin
          if (in_ch.byte_present) begin
            count_nxt = count_r + 61'd1;
            // bytes land little-endian; the fourth one completes the word
            case (pos[1:0])
              2'd0: wbuf_nxt[7:0]   = in_ch.message_byte;
              2'd1: wbuf_nxt[15:8]  = in_ch.message_byte;
              2'd2: wbuf_nxt[23:16] = in_ch.message_byte;
              2'd3: begin
                ram_we    = 1'b1;
                ram_wdata = {in_ch.message_byte, wbuf_r};
              end
              default: wbuf_nxt = wbuf_r;
            endcase
          end
          if (in_ch.byte_present && (pos == BLOCK_LAST)) begin
            ctrl.start = 1'b1;
            state_nxt  = ST_COMP;
            after_nxt  = in_ch.last_byte ? ST_PAD : ST_IN;
          end else if (in_ch.last_byte) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ram_we = 1'b1;
        case (pos[1:0])
          2'd0:    ram_wdata = {24'h0, PAD_BYTE};
          2'd1:    ram_wdata = {16'h0, PAD_BYTE, wbuf_r[7:0]};
          2'd2:    ram_wdata = {8'h0, PAD_BYTE, wbuf_r[15:0]};
          2'd3:    ram_wdata = {PAD_BYTE, wbuf_r};
          default: ram_wdata = '0;
        endcase
        zptr_nxt = pos[5:2] + 4'd1;
        if (pos[5:2] == ZERO_LAST_IDX) begin
          state_nxt = ST_LEN_LO;
        end else if (pos[5:2] == LEN_HI_IDX) begin
          // no room for the length: close this block, zero fill the next
          ctrl.start = 1'b1;
          state_nxt  = ST_COMP;
          after_nxt  = ST_ZERO;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = zptr_r;
        zptr_nxt  = zptr_r + 4'd1;   // wraps to word 0 after a spill block
        if (zptr_r == ZERO_LAST_IDX) begin
          state_nxt = ST_LEN_LO;
        end else if (zptr_r == LEN_HI_IDX) begin
          ctrl.start = 1'b1;
          state_nxt  = ST_COMP;
          after_nxt  = ST_ZERO;
        end
      end
      ST_LEN_LO: begin
        ram_we    = 1'b1;
        ram_waddr = LEN_LO_IDX;
        ram_wdata = {count_r[28:0], 3'b000};
        state_nxt = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        ram_we     = 1'b1;
        ram_waddr  = LEN_HI_IDX;
        ram_wdata  = count_r[60:29];
        ctrl.start = 1'b1;
        oidx_nxt   = 2'd0;
        state_nxt  = ST_COMP;
        after_nxt  = ST_OUT;
      end
      ST_COMP: begin
        if (stat.done) begin
          state_nxt = after_r;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            // back to the IV for the next message
            ctrl.reinit = 1'b1;
            count_nxt   = '0;
            state_nxt   = ST_IN;
          end
        end
      end
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IN;
      after_r <= ST_IN;
      count_r <= '0;
      zptr_r  <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      count_r <= count_nxt;
      zptr_r  <= zptr_nxt;
      oidx_r  <= oidx_nxt;
    end
    wbuf_r <= wbuf_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IN);
  assign out_ch.valid       = (state_r == ST_OUT);
  assign out_ch.digest_word = chain[oidx_r];
  assign out_ch.word_index  = oidx_r;
  assign out_ch.last_word   = (oidx_r == 2'd3);

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> !stat.busy)
    else $error("compression started while compressor busy");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !ram_we)
    else $error("buffer written during compression");

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (state_r == ST_COMP))
    else $error("compression done outside wait state");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=>
      (count_r == '0) && (chain == MD5_IV))
    else $error("no restart after final digest word");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_md5_stream_hash.sv -----
`timescale 1ns / 100ps

// Streaming MD5 bench: bytes go in one transaction at a time, digests come out
// as four 32-bit words per message and are checked against an in-bench model.
module tb_md5_stream_hash;

  // MD5 chaining start values, low word first
  localparam logic [31:0] IV_WORD0 = 32'h67452301;
  localparam logic [31:0] IV_WORD1 = 32'hefcdab89;
  localparam logic [31:0] IV_WORD2 = 32'h98badcfe;
  localparam logic [31:0] IV_WORD3 = 32'h10325476;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam int         LEN_FIELD  = 56;   // length field starts here in the last block
  localparam int         BLOCK_SIZE = 64;

  // Per-step additive constants, step 0 in the top word
  localparam logic [64*32-1:0] STEP_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {round, step[1:0]}, entry 0 in the top bits
  localparam logic [16*5-1:0] STEP_ROT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 200;  // > two compressions plus pad writes
  localparam int ITEM_TARGET      = 270;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_beat_t;

  logic clk;
  logic rst_n;

  md5sh_in_if  in_ch ();
  md5sh_out_if out_ch ();

  md5_stream_hash DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Hash model state
  logic [31:0] chain_st [4];
  logic [7:0]  blk_st [BLOCK_SIZE];
  logic [60:0] nbytes_st;     // wraps like the hardware counter

  digest_beat_t pending_digest [$];

  int  errors;
  int  items_sent;            // accepted transactions that carry a byte or close a message
  bit  in_no_gaps;            // sender back-to-back phase
  bit  out_no_stalls;         // receiver always-ready phase
  int  hold_len;              // request for one long receiver hold-off

  // --------------------------------------------------------------------------
  // Hash model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotl32(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void md5_restart();
    chain_st[0] = IV_WORD0;
    chain_st[1] = IV_WORD1;
    chain_st[2] = IV_WORD2;
    chain_st[3] = IV_WORD3;
    nbytes_st   = '0;
  endfunction

  // 64 steps over the buffered block, folded into the chaining words
  function automatic void md5_compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g, rnd;
    for (int w = 0; w < 16; w++)
      m[w] = {blk_st[4*w+3], blk_st[4*w+2], blk_st[4*w+1], blk_st[4*w]};
    a = chain_st[0];
    b = chain_st[1];
    c = chain_st[2];
    d = chain_st[3];
    for (int i = 0; i < 64; i++) begin
      rnd = i >> 4;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = a + f + m[g] + STEP_K[(63 - i)*32 +: 32];
      a = d;
      d = c;
      c = b;
      b = b + rotl32(t, STEP_ROT[(15 - ((rnd << 2) | (i & 3)))*5 +: 5]);
    end
    chain_st[0] = chain_st[0] + a;
    chain_st[1] = chain_st[1] + b;
    chain_st[2] = chain_st[2] + c;
    chain_st[3] = chain_st[3] + d;
  endfunction

  // One accepted transaction; queues the four digest words on a message end
  function automatic void md5_absorb(logic [7:0] b, logic present, logic last);
    int pos;
    logic [63:0] bitlen;
    digest_beat_t beat;
    if (present) begin
      pos = nbytes_st[5:0];
      blk_st[pos] = b;
      nbytes_st = nbytes_st + 61'd1;
      if (pos == BLOCK_SIZE - 1)
        md5_compress();
    end
    if (!last)
      return;
    pos = nbytes_st[5:0];
    bitlen = {nbytes_st, 3'b000};
    blk_st[pos] = PAD_MARK;
    pos = pos + 1;
    // no room for the length field: zero out this block and start another
    if (pos > LEN_FIELD) begin
      while (pos < BLOCK_SIZE) begin
        blk_st[pos] = 8'h00;
        pos = pos + 1;
      end
      md5_compress();
      pos = 0;
    end
    while (pos < LEN_FIELD) begin
      blk_st[pos] = 8'h00;
      pos = pos + 1;
    end
    for (int i = 0; i < 8; i++)
      blk_st[LEN_FIELD + i] = bitlen[8*i +: 8];
    md5_compress();
    for (int i = 0; i < 4; i++) begin
      beat.word = chain_st[i];
      beat.idx  = i[1:0];
      beat.last = (i == 3);
      pending_digest = {pending_digest, beat};
    end
    md5_restart();
  endfunction

  // --------------------------------------------------------------------------
  // Clock, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The worst case ends far before this timeout, which only catches a hang
  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Byte sender: random gap, then hold valid until the transaction is taken
  // --------------------------------------------------------------------------
  task automatic send_item(logic [7:0] b, logic present, logic last);
    int gap;
    gap = in_no_gaps ? 0 : $urandom_range(0, 13);
    // valid is lowered only here, in sender_quiet and at reset, so one update per step
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_byte <= b;
    in_ch.byte_present <= present;
    in_ch.last_byte    <= last;
    do @(posedge clk); while (!in_ch.ready);
    md5_absorb(b, present, last);
    if (present || last)
      items_sent++;
  endtask

  task automatic sender_quiet();
    in_ch.valid <= 1'b0;
  endtask

  // Random bytes, an idle transaction now and then, closed either on the last
  // byte or by a separate empty closing transaction
  task automatic send_message(int len, bit close_empty);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !close_empty);
    end
    if (close_empty || len == 0)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Drop valid first so the last transaction is not taken a second time
  task automatic wait_digests_drained();
    sender_quiet();
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Digest receiver: random stall per word, plus one long hold on request.
  // Leaves its wait loop on an accepted word or when a hold is asked for.
  // --------------------------------------------------------------------------
  initial begin : digest_receiver
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = out_no_stalls ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && hold_len == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Digest checker: each accepted word against the oldest expected one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : digest_check
    digest_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                 out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        errors++;
      end else begin
        want = pending_digest.pop_front();
        if (out_ch.digest_word !== want.word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   want.word, out_ch.digest_word);
          errors++;
        end
        if (out_ch.word_index !== want.idx) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   want.idx, out_ch.word_index);
          errors++;
        end
        if (out_ch.last_word !== want.last) begin
          $display("%0t: last_word expected %0b actual %0b", $time,
                   want.last, out_ch.last_word);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty message, idle transactions around "abc", single extreme bytes,
  // and a message closed by an empty transaction after its bytes
  task automatic test_directed();
    send_item(8'hA5, 1'b0, 1'b1);          // empty message
    send_item(8'h5A, 1'b0, 1'b0);          // idle, ignored
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);          // idle with a byte that must not count
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);          // "abc"
    send_item(8'h00, 1'b1, 1'b1);          // single 0x00
    send_item(8'hFF, 1'b1, 1'b1);          // single 0xFF
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);          // closed by an empty transaction
    send_item(8'h00, 1'b0, 1'b1);          // back-to-back empty message
    wait_digests_drained();
  endtask

  // Lengths where the pad and length field just fit, just spill into a second
  // block, fill the block to its last byte, and start right after a full block
  task automatic test_block_boundaries();
    int lens [4];
    lens[0] = LEN_FIELD - 1;
    lens[1] = LEN_FIELD;
    lens[2] = BLOCK_SIZE - 1;
    lens[3] = BLOCK_SIZE;
    foreach (lens[i]) begin
      in_no_gaps    = ($urandom_range(0, 2) == 0);
      out_no_stalls = ($urandom_range(0, 2) == 0);
      send_message(lens[i], 1'($urandom_range(0, 1)));
    end
    wait_digests_drained();
  endtask

  // Many short messages with shifting idle patterns on both sides
  task automatic test_short_messages();
    do begin
      in_no_gaps    = ($urandom_range(0, 3) == 0);
      out_no_stalls = ($urandom_range(0, 3) == 0);
      send_message($urandom_range(0, 9), $urandom_range(0, 3) == 0);
    end while (items_sent < ITEM_TARGET);
    wait_digests_drained();
  endtask

  // Receiver goes away for a long time while tiny messages keep coming, so
  // the finished digest waits on the output and the input side has to stall
  task automatic test_output_backpressure();
    in_no_gaps    = 1'b1;
    out_no_stalls = 1'b0;
    hold_len      = LONG_HOLD_CYCLES;
    for (int n = 0; n < 10; n++)
      send_message($urandom_range(0, 2), 1'($urandom_range(0, 1)));
    in_no_gaps = 1'b0;
    wait_digests_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    errors        = 0;
    items_sent    = 0;
    in_no_gaps    = 1'b0;
    out_no_stalls = 1'b0;
    hold_len      = 0;
    md5_restart();
    for (int i = 0; i < BLOCK_SIZE; i++)
      blk_st[i] = 8'h00;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.message_byte <= 8'h00;
    in_ch.byte_present <= 1'b0;
    in_ch.last_byte    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_block_boundaries();
    test_output_backpressure();
    test_short_messages();

    wait_digests_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- md5_stream_hash.f -----
src/md5sh_pkg.sv
src/md5sh_if.sv
src/md5sh_ram.sv
src/md5sh_compress.sv
src/md5_stream_hash.sv
dv/tb_md5_stream_hash.sv
